// ===== rtl/core/tme_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the tape machine execute unit.
package tme_pkg;

  localparam int TAPE_DEPTH = 65536;
  localparam int PTR_W      = $clog2(TAPE_DEPTH);
  localparam int ADDR_W     = 16;
  localparam int BYTE_W     = 8;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_LEFT  = 3'd2,
    OP_RIGHT = 3'd3,
    OP_OUT   = 3'd4,
    OP_IN    = 3'd5,
    OP_JZ    = 3'd6,
    OP_JNZ   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    op_t               opcode;
    logic [ADDR_W-1:0] operand;
    logic [ADDR_W-1:0] instr_addr;
    logic [BYTE_W-1:0] in_byte;
    logic              in_byte_valid;
  } in_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] next_addr;
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic              status;
  } out_rsp_t;

  typedef struct packed {
    logic clr_en;
    logic capture;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/tme_if.sv =====
`timescale 1ns / 1ps
// Request and result channel interfaces of the tape machine execute unit.
interface tme_in_if;
  logic              valid;
  logic              ready;
  tme_pkg::in_req_t  req;
  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface

interface tme_out_if;
  logic              valid;
  logic              ready;
  tme_pkg::out_rsp_t rsp;
  modport source (output valid, output rsp, input ready);
  modport sink (input valid, input rsp, output ready);
endinterface

// ===== rtl/core/tme_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: tape clear sweep, request accept and execute.
module tme_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tme_pkg::sts_t sts,
  output tme_pkg::cmd_t cmd
);

  tme_pkg::state_t st_r;
  tme_pkg::state_t st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tme_pkg::ST_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      tme_pkg::ST_CLEAR: begin
        if (sts.clr_last) st_nxt = tme_pkg::ST_IDLE;
      end
      tme_pkg::ST_IDLE: begin
        if (in_valid) st_nxt = tme_pkg::ST_EXEC;
      end
      tme_pkg::ST_EXEC: begin
        if (sts.out_free) st_nxt = tme_pkg::ST_IDLE;
      end
      default: st_nxt = tme_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.clr_en  = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (st_r)
      tme_pkg::ST_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      tme_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      tme_pkg::ST_EXEC: begin
        cmd.exec = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> st_r == tme_pkg::ST_EXEC)
    else $error("accepted request did not enter execute");

  a_exec_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> in_ready)
    else $error("unit not ready after execute");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_en |-> !in_ready && !cmd.exec)
    else $error("request taken during tape clear");

endmodule

// ===== rtl/core/tme_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: tape memory, data pointer, cell update, jump select, result register.
module tme_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  tme_pkg::cmd_t     cmd,
  output tme_pkg::sts_t     sts,
  input  tme_pkg::in_req_t  in_req,
  output logic              out_vld,
  input  logic              out_rdy,
  output tme_pkg::out_rsp_t out_rsp
);

  logic [tme_pkg::BYTE_W-1:0] tape_mem [tme_pkg::TAPE_DEPTH];

  tme_pkg::in_req_t           item_r;
  logic [tme_pkg::PTR_W-1:0]  dp_r;
  logic [tme_pkg::PTR_W-1:0]  dp_nxt;
  logic [tme_pkg::PTR_W-1:0]  clr_cnt_r;
  logic [tme_pkg::BYTE_W-1:0] cell_r;
  tme_pkg::out_rsp_t          out_rsp_r;
  tme_pkg::out_rsp_t          out_rsp_nxt;
  logic                       out_vld_r;

  logic [tme_pkg::ADDR_W-1:0] dp_ext;
  logic [tme_pkg::ADDR_W:0]   right_sum;
  logic [tme_pkg::ADDR_W-1:0] seq_addr;
  logic                       oob;
  logic                       wr_en;
  logic [tme_pkg::BYTE_W-1:0] wr_data;

  assign sts.clr_last = clr_cnt_r == tme_pkg::PTR_W'(tme_pkg::TAPE_DEPTH - 1);
  assign sts.out_free = !out_vld_r || out_rdy;
  assign out_vld      = out_vld_r;
  assign out_rsp      = out_rsp_r;

  assign dp_ext    = tme_pkg::ADDR_W'(dp_r);
  assign right_sum = {1'b0, dp_ext} + {1'b0, item_r.operand};
  assign seq_addr  = item_r.instr_addr + tme_pkg::ADDR_W'(1);

  always_comb begin
    dp_nxt      = dp_r;
    oob         = 1'b0;
    wr_en       = 1'b0;
    wr_data     = cell_r;
    out_rsp_nxt = '0;
    out_rsp_nxt.next_addr = seq_addr;
    case (item_r.opcode)
      tme_pkg::OP_ADD: begin
        wr_en   = 1'b1;
        wr_data = cell_r + item_r.operand[tme_pkg::BYTE_W-1:0];
      end
      tme_pkg::OP_SUB: begin
        wr_en   = 1'b1;
        wr_data = cell_r - item_r.operand[tme_pkg::BYTE_W-1:0];
      end
      tme_pkg::OP_LEFT: begin
        if (dp_ext < item_r.operand) begin
          oob = 1'b1;
        end else begin
          dp_nxt = tme_pkg::PTR_W'(dp_ext - item_r.operand);
        end
      end
      tme_pkg::OP_RIGHT: begin
        if (right_sum >= (tme_pkg::ADDR_W + 1)'(tme_pkg::TAPE_DEPTH)) begin
          oob = 1'b1;
        end else begin
          dp_nxt = right_sum[tme_pkg::PTR_W-1:0];
        end
      end
      tme_pkg::OP_OUT: begin
        out_rsp_nxt.out_byte  = cell_r;
        out_rsp_nxt.out_valid = 1'b1;
      end
      tme_pkg::OP_IN: begin
        wr_en   = item_r.in_byte_valid;
        wr_data = item_r.in_byte;
      end
      tme_pkg::OP_JZ: begin
        if (cell_r == '0) out_rsp_nxt.next_addr = item_r.operand;
      end
      tme_pkg::OP_JNZ: begin
        if (cell_r != '0) out_rsp_nxt.next_addr = item_r.operand;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
    if (oob) begin
      out_rsp_nxt.status    = 1'b1;
      out_rsp_nxt.next_addr = item_r.instr_addr;
    end
  end

  // single port tape: clear sweep or execute write, registered read at the pointer
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      tape_mem[clr_cnt_r] <= '0;
    end else if (cmd.exec && wr_en) begin
      tape_mem[dp_r] <= wr_data;
    end
    cell_r <= tape_mem[dp_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_req;
    if (cmd.exec) out_rsp_r <= out_rsp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_r      <= '0;
      clr_cnt_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.clr_en) clr_cnt_r <= clr_cnt_r + tme_pkg::PTR_W'(1);
      if (cmd.exec) begin
        dp_r      <= dp_nxt;
        out_vld_r <= 1'b1;
      end else if (out_rdy) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  a_exec_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!out_vld_r || out_rdy))
    else $error("result register overwritten");

  a_dp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    dp_r <= tme_pkg::PTR_W'(tme_pkg::TAPE_DEPTH - 1))
    else $error("data pointer beyond tape");

  a_oob_holds_dp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && oob |=> $stable(dp_r) && out_rsp_r.status)
    else $error("out of bounds move changed pointer");

endmodule

// ===== rtl/core/tape_machine_execute_unit.sv =====
`timescale 1ns / 1ps
// Top level of the tape machine execute unit.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------
//  in_ch    | in        | opcode, operand, instr_addr, in_byte, in_byte_valid
//  out_ch   | out       | next_addr, out_byte, out_valid, status
//
// Each request is accepted in ST_IDLE, then executed in ST_EXEC on the registered tape read;
// the single tape RAM is read at the pointer and the updated cell is written back.
// After reset a clear sweep zeroes all TAPE_DEPTH cells (65536), with in_ch.ready low.
// The result register lets a new request be accepted while a result waits;
// execute holds while that register is full and out_ch.ready is low.
module tape_machine_execute_unit (
  input  logic      clk,
  input  logic      rst_n,
  tme_in_if.sink    in_ch,
  tme_out_if.source out_ch
);

  tme_pkg::cmd_t cmd;
  tme_pkg::sts_t sts;

  tme_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tme_datapath u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_req  (in_ch.req),
    .out_vld (out_ch.valid),
    .out_rdy (out_ch.ready),
    .out_rsp (out_ch.rsp)
  );

endmodule

// ===== tb/sv/tb_tape_machine_execute_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the tape machine execute unit: directed and random requests.
module tb_tape_machine_execute_unit;

  localparam int IDLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;

  class tape_scoreboard;
    bit [7:0]           cells [tme_pkg::TAPE_DEPTH];
    int unsigned        dp;
    tme_pkg::out_rsp_t  expected_results [$];
    int                 errors;
    int                 n_requests;
    int                 n_results;
    int                 n_bounds;
    int                 n_outputs;
    int                 n_jumps;

    function bit [7:0] cur_cell();
      return cells[dp];
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_request(tme_pkg::in_req_t r);
      tme_pkg::out_rsp_t e;
      e = '0;
      e.next_addr = r.instr_addr + 16'd1;
      n_requests++;
      case (r.opcode)
        tme_pkg::OP_ADD: cells[dp] = cells[dp] + r.operand[7:0];
        tme_pkg::OP_SUB: cells[dp] = cells[dp] - r.operand[7:0];
        tme_pkg::OP_LEFT: begin
          if (dp < r.operand) begin
            e.status = 1'b1;
            e.next_addr = r.instr_addr;
          end else begin
            dp = dp - r.operand;
          end
        end
        tme_pkg::OP_RIGHT: begin
          if (dp + r.operand >= tme_pkg::TAPE_DEPTH) begin
            e.status = 1'b1;
            e.next_addr = r.instr_addr;
          end else begin
            dp = dp + r.operand;
          end
        end
        tme_pkg::OP_OUT: begin
          e.out_byte = cells[dp];
          e.out_valid = 1'b1;
          n_outputs++;
        end
        tme_pkg::OP_IN: if (r.in_byte_valid) cells[dp] = r.in_byte;
        tme_pkg::OP_JZ: if (cells[dp] == 8'd0) begin
          e.next_addr = r.operand;
          n_jumps++;
        end
        tme_pkg::OP_JNZ: if (cells[dp] != 8'd0) begin
          e.next_addr = r.operand;
          n_jumps++;
        end
        default: ;
      endcase
      if (e.status) n_bounds++;
      expected_results.push_back(e);
    endfunction

    function void check_result(tme_pkg::out_rsp_t a);
      tme_pkg::out_rsp_t e;
      n_results++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result next_addr=%h out_byte=%h out_valid=%b status=%b",
                 $time, a.next_addr, a.out_byte, a.out_valid, a.status);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (a.next_addr !== e.next_addr) begin
        $display("%0t: next_addr expected %h actual %h", $time, e.next_addr, a.next_addr);
        errors++;
      end
      if (a.out_byte !== e.out_byte) begin
        $display("%0t: out_byte expected %h actual %h", $time, e.out_byte, a.out_byte);
        errors++;
      end
      if (a.out_valid !== e.out_valid) begin
        $display("%0t: out_valid expected %b actual %b", $time, e.out_valid, a.out_valid);
        errors++;
      end
      if (a.status !== e.status) begin
        $display("%0t: status expected %b actual %b", $time, e.status, a.status);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tme_in_if  in_ch ();
  tme_out_if out_ch ();

  tape_machine_execute_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tape_scoreboard sb;
  bit rx_quiet;
  bit rx_hold_req;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    sb = new();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.req <= '0;
    out_ch.ready <= 1'b0;
  end

  // result side: random back-pressure, quiet stretches, one long hold-off
  initial begin : sink_proc
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rx_quiet || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.rsp);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, sb.pending());
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic tme_pkg::in_req_t mk(tme_pkg::op_t op, logic [15:0] operand,
                                          logic [15:0] addr, logic [7:0] ib, logic ibv);
    tme_pkg::in_req_t r;
    r.opcode = op;
    r.operand = operand;
    r.instr_addr = addr;
    r.in_byte = ib;
    r.in_byte_valid = ibv;
    return r;
  endfunction

  function automatic tme_pkg::in_req_t rand_request();
    tme_pkg::in_req_t r;
    int unsigned k;
    r.opcode = tme_pkg::op_t'($urandom_range(0, 7));
    r.operand = 16'($urandom);
    r.instr_addr = ($urandom_range(0, 19) == 0) ? 16'hFFFF : 16'($urandom);
    r.in_byte = 8'($urandom);
    r.in_byte_valid = ($urandom_range(0, 4) != 0);
    k = $urandom_range(0, 9);
    case (r.opcode)
      tme_pkg::OP_LEFT: begin
        if (k < 5) r.operand = 16'($urandom_range(0, 7));
        else if (k == 5) r.operand = 16'(sb.dp);
        else if (k == 6) r.operand = 16'(sb.dp + 1);
        else if (k == 7) r.operand = 16'(sb.dp - 1);
      end
      tme_pkg::OP_RIGHT: begin
        if (k < 5) r.operand = 16'($urandom_range(0, 7));
        else if (k == 5) r.operand = 16'(65535 - sb.dp);
        else if (k == 6) r.operand = 16'(65536 - sb.dp);
        else if (k == 7) r.operand = 16'(65534 - sb.dp);
      end
      // steer the cell back to zero now and then so both jump outcomes occur
      tme_pkg::OP_SUB: if (k < 2) r.operand[7:0] = sb.cur_cell();
      tme_pkg::OP_ADD: if (k < 2) r.operand[7:0] = 8'(0 - sb.cur_cell());
      default: ;
    endcase
    return r;
  endfunction

  task automatic send(tme_pkg::in_req_t r);
    in_ch.valid <= 1'b1;
    in_ch.req <= r;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sb.note_request(r);
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 99) < 6) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_random(int n, bit gaps);
    repeat (n) begin
      send(rand_request());
      if (gaps) maybe_gap();
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stim_proc
    rx_quiet = 1'b1;
    rx_hold_req = 1'b0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: wrap, modulo ops, end of input, both jump outcomes, bounds at both tape ends
    send(mk(tme_pkg::OP_OUT,   16'h0000, 16'h0000, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_JZ,    16'hABCD, 16'h0001, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_JNZ,   16'h1234, 16'hFFFF, 8'hFF, 1'b1));
    send(mk(tme_pkg::OP_ADD,   16'hFFFF, 16'h0010, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_OUT,   16'hFFFF, 16'h0011, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_JNZ,   16'h0000, 16'h0012, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_JZ,    16'hFFFF, 16'h0013, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_SUB,   16'h0101, 16'h0014, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_IN,    16'h0000, 16'h0015, 8'h5A, 1'b1));
    send(mk(tme_pkg::OP_IN,    16'hFFFF, 16'h0016, 8'hFF, 1'b0));
    send(mk(tme_pkg::OP_OUT,   16'h0000, 16'h0017, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_LEFT,  16'h0001, 16'h0018, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_LEFT,  16'h0000, 16'h0019, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_RIGHT, 16'h0000, 16'h001A, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_RIGHT, 16'hFFFF, 16'h001B, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_ADD,   16'h0007, 16'h001C, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_OUT,   16'h0000, 16'h001D, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_RIGHT, 16'h0001, 16'hFFFF, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_LEFT,  16'h0001, 16'h001E, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_RIGHT, 16'h0002, 16'h001F, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_LEFT,  16'hFFFE, 16'h0020, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_OUT,   16'h0000, 16'h0021, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_LEFT,  16'hFFFF, 16'h0022, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_RIGHT, 16'hFFFF, 16'h0023, 8'h00, 1'b0));
    send(mk(tme_pkg::OP_LEFT,  16'hFFFF, 16'h0024, 8'h00, 1'b0));

    rx_quiet = 1'b0;
    send_random(400, 1'b1);

    // sender pause until every result is back
    drain();

    // long sink hold-off with the source pushing back-to-back
    rx_hold_req = 1'b1;
    send_random(60, 1'b0);

    rx_quiet = 1'b1;
    send_random(200, 1'b0);

    rx_quiet = 1'b0;
    send_random(520, 1'b1);

    drain();
    repeat (10) @(posedge clk);

    $display("Ran %0d requests, %0d results: %0d bound faults, %0d byte outputs, %0d jumps taken",
             sb.n_requests, sb.n_results, sb.n_bounds, sb.n_outputs, sb.n_jumps);
    $display("Covered back-pressure, a %0d-cycle sink hold-off and a full drain pause",
             HOLD_CYCLES);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
